### design/tcbpa_pkg.sv
package tcbpa_pkg;

	// Field widths
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam int SIZE_W    = 16;
	localparam int IDX_W     = 4;
	localparam int CNT_W     = 5;
	localparam int TOT_W     = 32;

	// Default pool geometry
	localparam int SMALL_BLOCKS_DEF  = 16;
	localparam int MEDIUM_BLOCKS_DEF = 16;
	localparam int LARGE_BLOCKS_DEF  = 8;

	// Register reset values
	localparam logic [CFG_W-1:0] SMALL_BYTES_RST  = 13'd64;
	localparam logic [CFG_W-1:0] MEDIUM_BYTES_RST = 13'd256;
	localparam logic [CFG_W-1:0] LARGE_BYTES_RST  = 13'd512;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SMALL_BYTES  = 2'd0,
		REG_MEDIUM_BYTES = 2'd1,
		REG_LARGE_BYTES  = 2'd2,
		REG_NONE         = 2'd3
	} reg_idx_t;

	// Request kinds
	typedef enum logic [1:0] {
		KIND_ALLOC = 2'd0,
		KIND_FREE  = 2'd1,
		KIND_STATS = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	// Pool classes
	typedef enum logic [1:0] {
		CLS_SMALL  = 2'd0,
		CLS_MEDIUM = 2'd1,
		CLS_LARGE  = 2'd2,
		CLS_NULL   = 2'd3
	} cls_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FAIL    = 2'd1,
		ST_IGNORED = 2'd2,
		ST_FOREIGN = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [SIZE_W-1:0] request_size;
		logic [1:0]        pool_class;
		logic [IDX_W-1:0]  block_index;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [1:0]       granted_class;
		logic [IDX_W-1:0] granted_index;
		logic [4:0]       small_in_use;
		logic [4:0]       medium_in_use;
		logic [3:0]       large_in_use;
		logic [4:0]       peak_sm;
		logic [4:0]       peak_md;
		logic [3:0]       peak_lg;
		logic [TOT_W-1:0] alloc_total;
		logic [TOT_W-1:0] free_total;
		logic [TOT_W-1:0] fail_total;
	} rsp_t;

	// Per-class update command from the decision logic
	typedef struct packed {
		logic             grab;
		logic             drop;
		logic [IDX_W-1:0] drop_idx;
		logic             snap;
	} cls_ctrl_t;

	// Per-class view back to the decision logic
	typedef struct packed {
		logic             has_free;
		logic [IDX_W-1:0] free_idx;
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] peak;
	} cls_stat_t;

endpackage

### design/tcbpa_class.sv
module tcbpa_class #(
	parameter int BLOCKS = tcbpa_pkg::SMALL_BLOCKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tcbpa_pkg::cls_ctrl_t  ctrl,
	output tcbpa_pkg::cls_stat_t  stat
);

	localparam int CW = $clog2(BLOCKS + 1);

	logic [BLOCKS-1:0] used_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     peak_q;
	logic              has_free;
	logic [tcbpa_pkg::IDX_W-1:0] free_idx;
	logic [CW-1:0]     count_inc;

	// Find the lowest clear bit of the bitmap
	always_comb begin
		has_free = 1'b0;
		free_idx = '0;
		for (int i = BLOCKS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				has_free = 1'b1;
				free_idx = tcbpa_pkg::IDX_W'(i);
			end
		end
	end

	assign count_inc = count_q + CW'(1);

	// Set the granted bit, clear the freed bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			for (int i = 0; i < BLOCKS; i++) begin
				if (ctrl.grab && free_idx == tcbpa_pkg::IDX_W'(i)) begin
					used_q[i] <= 1'b1;
				end else if (ctrl.drop && ctrl.drop_idx == tcbpa_pkg::IDX_W'(i)) begin
					used_q[i] <= 1'b0;
				end
			end
		end
	end

	// Track use count and high mark; a drop never takes the count below zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			peak_q  <= '0;
		end else begin
			if (ctrl.grab) begin
				count_q <= count_inc;
				if (count_inc > peak_q) begin
					peak_q <= count_inc;
				end
			end else if (ctrl.drop) begin
				if (count_q != '0) begin
					count_q <= count_q - CW'(1);
				end
			end else if (ctrl.snap) begin
				peak_q <= count_q;
			end
		end
	end

	assign stat.has_free = has_free;
	assign stat.free_idx = free_idx;
	assign stat.count    = tcbpa_pkg::CNT_W'(count_q);
	assign stat.peak     = tcbpa_pkg::CNT_W'(peak_q);

	a_grab_needs_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.grab |-> has_free)
		else $error("grab issued on a full class");

	a_grab_drop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.grab && ctrl.drop))
		else $error("grab and drop in the same cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(BLOCKS))
		else $error("use count exceeds class size");

	a_grab_counts: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.grab |=> count_q == $past(count_inc))
		else $error("grab did not raise the use count");

endmodule

### design/three_class_block_pool_allocator.sv
// Three-class block pool allocator.
// Input channel: a transaction (req) is taken at each rising edge with start high and
// busy low. busy stays low, so a new request may be issued every cycle.
// Kinds: allocate by byte size, free by class and index, reset statistics.
// Output channel: exactly one result per request, shown on rsp for one cycle with
// done high. The receiver cannot hold results off and none is needed.
// Result path: the request passes the input register (valid_s1, req_s1), then one pass
// of find-first-free and counter update into the state and result registers, which
// drive done and rsp. Throughput: one request per cycle, set by the read-modify-write
// of the per-class bitmaps and counters.
// Configuration: cfg_we/cfg_idx/cfg_data write the three class size limits; write
// only while no request is outstanding. An index beyond the list is ignored.
// Reset (arst_n low): all bitmaps, counts, peaks and totals clear, size limits
// return to 64, 256 and 512 bytes, and no result is pending.
module three_class_block_pool_allocator #(
	parameter int SMALL_BLOCKS  = tcbpa_pkg::SMALL_BLOCKS_DEF,
	parameter int MEDIUM_BLOCKS = tcbpa_pkg::MEDIUM_BLOCKS_DEF,
	parameter int LARGE_BLOCKS  = tcbpa_pkg::LARGE_BLOCKS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  tcbpa_pkg::req_t                     req,
	output logic                                done,
	output tcbpa_pkg::rsp_t                     rsp,
	input  logic                                cfg_we,
	input  logic [tcbpa_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [tcbpa_pkg::CFG_W-1:0]         cfg_data
);

	logic [tcbpa_pkg::CFG_W-1:0]  small_bytes_q, medium_bytes_q, large_bytes_q;
	logic                         valid_s1;
	tcbpa_pkg::req_t              req_s1;
	logic                         done_s2;
	logic [1:0]                   status_s2;
	logic [1:0]                   gclass_s2;
	logic [tcbpa_pkg::IDX_W-1:0]  gidx_s2;
	logic [tcbpa_pkg::TOT_W-1:0]  alloc_total_q, free_total_q, fail_total_q;

	tcbpa_pkg::cls_ctrl_t         sm_ctrl, md_ctrl, lg_ctrl;
	tcbpa_pkg::cls_stat_t         sm_stat, md_stat, lg_stat;

	logic                         is_alloc, is_free, is_stats;
	logic                         fit_sm, fit_md, fit_lg;
	logic                         try_sm, try_md, try_lg, granted;
	logic                         rng_sm, rng_md, rng_lg, dropped;
	logic [tcbpa_pkg::IDX_W:0]    idx_ext;
	logic [1:0]                   status_d;
	logic [1:0]                   gclass_d;
	logic [tcbpa_pkg::IDX_W-1:0]  gidx_d;

	assign busy = 1'b0;

	// Hold the class size limits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_bytes_q  <= tcbpa_pkg::SMALL_BYTES_RST;
			medium_bytes_q <= tcbpa_pkg::MEDIUM_BYTES_RST;
			large_bytes_q  <= tcbpa_pkg::LARGE_BYTES_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				tcbpa_pkg::REG_SMALL_BYTES:  small_bytes_q  <= cfg_data;
				tcbpa_pkg::REG_MEDIUM_BYTES: medium_bytes_q <= cfg_data;
				tcbpa_pkg::REG_LARGE_BYTES:  large_bytes_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the incoming transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
	end

	// Decode the request
	assign is_alloc = valid_s1 && req_s1.kind == tcbpa_pkg::KIND_ALLOC
		&& req_s1.request_size != '0;
	assign is_free  = valid_s1 && req_s1.kind == tcbpa_pkg::KIND_FREE
		&& req_s1.pool_class != tcbpa_pkg::CLS_NULL;
	assign is_stats = valid_s1 && req_s1.kind == tcbpa_pkg::KIND_STATS;

	// Pick the first fitting class, in the order small, medium, large, that still has a free block
	assign fit_sm = req_s1.request_size <= tcbpa_pkg::SIZE_W'(small_bytes_q);
	assign fit_md = req_s1.request_size <= tcbpa_pkg::SIZE_W'(medium_bytes_q);
	assign fit_lg = req_s1.request_size <= tcbpa_pkg::SIZE_W'(large_bytes_q);
	assign try_sm = fit_sm && sm_stat.has_free;
	assign try_md = !try_sm && fit_md && md_stat.has_free;
	assign try_lg = !try_sm && !try_md && fit_lg && lg_stat.has_free;
	assign granted = try_sm || try_md || try_lg;

	// Check the freed index against the class size
	assign idx_ext = {1'b0, req_s1.block_index};
	assign rng_sm  = req_s1.pool_class == tcbpa_pkg::CLS_SMALL
		&& idx_ext < (tcbpa_pkg::IDX_W + 1)'(SMALL_BLOCKS);
	assign rng_md  = req_s1.pool_class == tcbpa_pkg::CLS_MEDIUM
		&& idx_ext < (tcbpa_pkg::IDX_W + 1)'(MEDIUM_BLOCKS);
	assign rng_lg  = req_s1.pool_class == tcbpa_pkg::CLS_LARGE
		&& idx_ext < (tcbpa_pkg::IDX_W + 1)'(LARGE_BLOCKS);
	assign dropped = rng_sm || rng_md || rng_lg;

	// Drive the class units
	assign sm_ctrl = '{grab: is_alloc && try_sm, drop: is_free && rng_sm,
		drop_idx: req_s1.block_index, snap: is_stats};
	assign md_ctrl = '{grab: is_alloc && try_md, drop: is_free && rng_md,
		drop_idx: req_s1.block_index, snap: is_stats};
	assign lg_ctrl = '{grab: is_alloc && try_lg, drop: is_free && rng_lg,
		drop_idx: req_s1.block_index, snap: is_stats};

	tcbpa_class #(.BLOCKS(SMALL_BLOCKS)) u_small (
		.clk(clk), .arst_n(arst_n), .ctrl(sm_ctrl), .stat(sm_stat)
	);

	tcbpa_class #(.BLOCKS(MEDIUM_BLOCKS)) u_medium (
		.clk(clk), .arst_n(arst_n), .ctrl(md_ctrl), .stat(md_stat)
	);

	tcbpa_class #(.BLOCKS(LARGE_BLOCKS)) u_large (
		.clk(clk), .arst_n(arst_n), .ctrl(lg_ctrl), .stat(lg_stat)
	);

	// Form status and granted block
	always_comb begin
		status_d = tcbpa_pkg::ST_IGNORED;
		gclass_d = tcbpa_pkg::CLS_SMALL;
		gidx_d   = '0;
		if (is_alloc) begin
			if (granted) begin
				status_d = tcbpa_pkg::ST_OK;
				if (try_sm) begin
					gidx_d = sm_stat.free_idx;
				end else if (try_md) begin
					gclass_d = tcbpa_pkg::CLS_MEDIUM;
					gidx_d   = md_stat.free_idx;
				end else begin
					gclass_d = tcbpa_pkg::CLS_LARGE;
					gidx_d   = lg_stat.free_idx;
				end
			end else begin
				status_d = tcbpa_pkg::ST_FAIL;
			end
		end else if (is_free) begin
			status_d = dropped ? tcbpa_pkg::ST_OK : tcbpa_pkg::ST_FOREIGN;
		end else if (is_stats) begin
			status_d = tcbpa_pkg::ST_OK;
		end
	end

	// Advance the wrapping totals; a stats request clears them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_total_q <= '0;
			free_total_q  <= '0;
			fail_total_q  <= '0;
		end else if (is_stats) begin
			alloc_total_q <= '0;
			free_total_q  <= '0;
			fail_total_q  <= '0;
		end else begin
			if (is_alloc) begin
				alloc_total_q <= alloc_total_q + tcbpa_pkg::TOT_W'(1);
				if (!granted) begin
					fail_total_q <= fail_total_q + tcbpa_pkg::TOT_W'(1);
				end
			end
			if (is_free) begin
				free_total_q <= free_total_q + tcbpa_pkg::TOT_W'(1);
			end
		end
	end

	// Register the result strobe and per-request fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_s2 <= status_d;
			gclass_s2 <= gclass_d;
			gidx_s2   <= gidx_d;
		end
	end

	// Counters come straight from the state registers, updated at the same edge
	assign done               = done_s2;
	assign rsp.status         = status_s2;
	assign rsp.granted_class  = gclass_s2;
	assign rsp.granted_index  = gidx_s2;
	assign rsp.small_in_use   = sm_stat.count;
	assign rsp.medium_in_use  = md_stat.count;
	assign rsp.large_in_use   = lg_stat.count[3:0];
	assign rsp.peak_sm        = sm_stat.peak;
	assign rsp.peak_md        = md_stat.peak;
	assign rsp.peak_lg        = lg_stat.peak[3:0];
	assign rsp.alloc_total    = alloc_total_q;
	assign rsp.free_total     = free_total_q;
	assign rsp.fail_total     = fail_total_q;

	a_one_result_each: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("accepted request produced no result");

	a_fail_only_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(is_alloc && !granted) |=> fail_total_q == $past(fail_total_q) + tcbpa_pkg::TOT_W'(1))
		else $error("failed allocation not counted");

	a_single_grab: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({sm_ctrl.grab, md_ctrl.grab, lg_ctrl.grab}))
		else $error("more than one class granted");

endmodule

### bench/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tcbpa_pkg::*;

	// Tracks pool occupancy and totals; holds the responses still owed by the block
	class pool_tracker;
		bit [15:0]       used_map [3];
		int unsigned     in_use [3];
		int unsigned     peak [3];
		int unsigned     blocks [3];
		bit [CFG_W-1:0]  size_lim [3];
		bit [TOT_W-1:0]  alloc_tot;
		bit [TOT_W-1:0]  free_tot;
		bit [TOT_W-1:0]  fail_tot;
		rsp_t            pending_rsp [$];
		int              errors;
		int              checked;

		function new();
			blocks[0] = SMALL_BLOCKS_DEF;
			blocks[1] = MEDIUM_BLOCKS_DEF;
			blocks[2] = LARGE_BLOCKS_DEF;
			size_lim[0] = SMALL_BYTES_RST;
			size_lim[1] = MEDIUM_BYTES_RST;
			size_lim[2] = LARGE_BYTES_RST;
		endfunction

		// Track a size limit write; the spare index changes nothing
		function void set_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == REG_SMALL_BYTES) begin
				size_lim[0] = val;
			end else if (idx == REG_MEDIUM_BYTES) begin
				size_lim[1] = val;
			end else if (idx == REG_LARGE_BYTES) begin
				size_lim[2] = val;
			end
		endfunction

		// Take the lowest free block of a class, -1 when the class is full
		function int take_block(int c);
			for (int i = 0; i < blocks[c]; i++) begin
				if (!used_map[c][i]) begin
					used_map[c][i] = 1'b1;
					in_use[c]++;
					if (in_use[c] > peak[c]) begin
						peak[c] = in_use[c];
					end
					return i;
				end
			end
			return -1;
		endfunction

		// Apply one accepted transaction and queue the response it must produce
		function void note_request(req_t r);
			rsp_t e;
			int   got;
			int   c;
			e = '0;
			e.status = ST_IGNORED;
			got = -1;
			case (r.kind)
				KIND_ALLOC: begin
					if (r.request_size != '0) begin
						alloc_tot++;
						// try classes in fixed order, falling through when full
						for (c = 0; c < 3; c++) begin
							if (got < 0 && r.request_size <= size_lim[c]) begin
								got = take_block(c);
								if (got >= 0) begin
									e.granted_class = 2'(c);
								end
							end
						end
						if (got >= 0) begin
							e.status = ST_OK;
							e.granted_index = 4'(got);
						end else begin
							e.status = ST_FAIL;
							e.granted_class = '0;
							fail_tot++;
						end
					end
				end
				KIND_FREE: begin
					if (r.pool_class != CLS_NULL) begin
						free_tot++;
						e.status = ST_FOREIGN;
						c = r.pool_class;
						if (r.block_index < blocks[c]) begin
							// clear even an unused block; floor the count at zero
							used_map[c][r.block_index] = 1'b0;
							if (in_use[c] > 0) begin
								in_use[c]--;
							end
							e.status = ST_OK;
						end
					end
				end
				KIND_STATS: begin
					alloc_tot = '0;
					free_tot = '0;
					fail_tot = '0;
					for (c = 0; c < 3; c++) begin
						peak[c] = in_use[c];
					end
					e.status = ST_OK;
				end
				default: begin
				end
			endcase
			e.small_in_use  = 5'(in_use[0]);
			e.medium_in_use = 5'(in_use[1]);
			e.large_in_use  = 4'(in_use[2]);
			e.peak_sm       = 5'(peak[0]);
			e.peak_md       = 5'(peak[1]);
			e.peak_lg       = 4'(peak[2]);
			e.alloc_total   = alloc_tot;
			e.free_total    = free_tot;
			e.fail_total    = fail_tot;
			pending_rsp.push_back(e);
		endfunction

		function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
			if (exp !== act) begin
				errors++;
				$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp, act);
			end
		endfunction

		// Compare one response with the oldest one owed
		function void check_result(rsp_t a);
			rsp_t e;
			if (pending_rsp.size() == 0) begin
				errors++;
				$display("%0t: response with no request outstanding: expected none, actual %h",
					$time, a);
				return;
			end
			e = pending_rsp.pop_front();
			checked++;
			compare_field("status", e.status, a.status);
			compare_field("granted_class", e.granted_class, a.granted_class);
			compare_field("granted_index", e.granted_index, a.granted_index);
			compare_field("small_in_use", e.small_in_use, a.small_in_use);
			compare_field("medium_in_use", e.medium_in_use, a.medium_in_use);
			compare_field("large_in_use", e.large_in_use, a.large_in_use);
			compare_field("peak_sm", e.peak_sm, a.peak_sm);
			compare_field("peak_md", e.peak_md, a.peak_md);
			compare_field("peak_lg", e.peak_lg, a.peak_lg);
			compare_field("alloc_total", e.alloc_total, a.alloc_total);
			compare_field("free_total", e.free_total, a.free_total);
			compare_field("fail_total", e.fail_total, a.fail_total);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	req_t                 req;
	logic                 done;
	rsp_t                 rsp;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;

	pool_tracker pool;
	int          items_sent;
	int          settings_run;

	three_class_block_pool_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Sample both channels and the register port at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				pool.check_result(rsp);
			end
			if (cfg_we) begin
				pool.set_size(cfg_idx, cfg_data);
			end
			if (start && !busy) begin
				pool.note_request(req);
			end
		end
	end

	// Hold one transaction until the block takes it
	task automatic send_req(input req_t r);
		@(negedge clk);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	task automatic idle_cycle();
		@(negedge clk);
		start <= 1'b0;
	endtask

	// Stop issuing and wait until every owed response has come back
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pool.pending_rsp.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_size(input reg_idx_t idx, input int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= CFG_W'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic req_t mk_alloc(int sz);
		req_t r;
		r = '0;
		r.kind = KIND_ALLOC;
		r.request_size = SIZE_W'(sz);
		return r;
	endfunction

	function automatic req_t mk_free(cls_t c, int idx);
		req_t r;
		r = '0;
		r.kind = KIND_FREE;
		r.pool_class = c;
		r.block_index = IDX_W'(idx);
		return r;
	endfunction

	function automatic req_t mk_kind(kind_t k);
		req_t r;
		r = '0;
		r.kind = k;
		return r;
	endfunction

	// Favor sizes on and around the class limits
	function automatic logic [SIZE_W-1:0] pick_size();
		int p;
		int b;
		p = $urandom_range(99);
		if (p < 8) begin
			return SIZE_W'($urandom());
		end
		if (p < 12) begin
			return '0;
		end
		if (p < 45) begin
			b = pool.size_lim[$urandom_range(2)] + int'($urandom_range(2)) - 1;
			if (b < 1) begin
				b = 1;
			end
			return SIZE_W'(b);
		end
		return SIZE_W'($urandom_range(600, 1));
	endfunction

	// Build one random transaction: mostly allocs and frees of live blocks, some noise
	function automatic req_t rand_req(int alloc_pct);
		req_t r;
		int   p;
		int   c;
		int   idx;
		r.kind = 2'($urandom());
		r.request_size = SIZE_W'($urandom());
		r.pool_class = 2'($urandom());
		r.block_index = IDX_W'($urandom());
		p = $urandom_range(99);
		if (p < alloc_pct) begin
			r.kind = KIND_ALLOC;
			r.request_size = pick_size();
		end else begin
			p = $urandom_range(99);
			if (p < 78) begin
				r.kind = KIND_FREE;
				c = $urandom_range(2);
				idx = $urandom_range(pool.blocks[c] - 1);
				repeat (4) begin
					if (!pool.used_map[c][idx]) begin
						idx = $urandom_range(pool.blocks[c] - 1);
					end
				end
				r.pool_class = 2'(c);
				r.block_index = IDX_W'(idx);
			end else if (p < 86) begin
				r.kind = KIND_STATS;
			end else if (p < 90) begin
				r.kind = KIND_NONE;
			end else if (p < 94) begin
				r.kind = KIND_FREE;
				r.pool_class = CLS_NULL;
			end else begin
				r.kind = KIND_FREE;
				r.pool_class = CLS_LARGE;
				r.block_index = IDX_W'($urandom_range(15, LARGE_BLOCKS_DEF));
			end
		end
		return r;
	endfunction

	// Program the three limits, then run random traffic with a pause mid-way
	task automatic run_phase(input int small_b, input int medium_b, input int large_b,
		input int n, input int alloc_pct, input bit no_idle);
		drain();
		write_size(REG_SMALL_BYTES, small_b);
		write_size(REG_MEDIUM_BYTES, medium_b);
		write_size(REG_LARGE_BYTES, large_b);
		settings_run++;
		for (int i = 0; i < n; i++) begin
			if (i == n / 2) begin
				drain();
			end
			if (!no_idle) begin
				while ($urandom_range(99) < 17) idle_cycle();
			end
			send_req(rand_req(alloc_pct));
		end
	endtask

	initial begin
		pool = new();
		items_sent = 0;
		settings_run = 0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_SMALL_BYTES;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: class boundaries, failures, odd frees, stats, unknown kind
		send_req(mk_alloc(0));
		send_req(mk_alloc(1));
		send_req(mk_alloc(64));
		send_req(mk_alloc(65));
		send_req(mk_alloc(256));
		send_req(mk_alloc(257));
		send_req(mk_alloc(512));
		send_req(mk_alloc(513));
		send_req(mk_alloc(16'hFFFF));
		send_req(mk_free(CLS_NULL, 15));
		send_req(mk_free(CLS_LARGE, 8));
		send_req(mk_free(CLS_LARGE, 15));
		send_req(mk_free(CLS_SMALL, 0));
		send_req(mk_free(CLS_SMALL, 0));
		send_req(mk_free(CLS_MEDIUM, 15));
		send_req(mk_kind(KIND_NONE));
		send_req(mk_kind(KIND_STATS));
		send_req(mk_alloc(1));
		send_req(mk_free(CLS_SMALL, 1));
		send_req(mk_free(CLS_SMALL, 0));
		send_req(mk_free(CLS_SMALL, 2));
		send_req(mk_free(CLS_LARGE, 7));
		send_req(mk_kind(KIND_STATS));

		// Random: several limit settings, extremes and reversed order among them
		run_phase(64, 256, 512, 200, 60, 1'b0);
		run_phase(4096, 4096, 4096, 200, 90, 1'b0);
		run_phase(0, 0, 0, 80, 50, 1'b0);
		run_phase(8191, 1, 100, 200, 65, 1'b1);
		run_phase(1, 1, 1, 150, 60, 1'b0);
		run_phase($urandom_range(4096, 1), $urandom_range(4096, 1), $urandom_range(4096, 1),
			200, 55, 1'b0);
		run_phase(64, 256, 512, 200, 35, 1'b0);
		run_phase($urandom_range(8191), $urandom_range(8191), $urandom_range(8191),
			170, 70, 1'b0);

		drain();
		repeat (4) @(posedge clk);
		$display("Checked %0d responses for %0d requests across %0d limit settings",
			pool.checked, items_sent, settings_run);
		$display("Covered class fall-through, full and oversize failures, odd frees, stats");
		if (pool.errors == 0 && pool.pending_rsp.size() == 0) begin
			$display("three_class_block_pool_allocator regression: pass");
		end else begin
			$display("three_class_block_pool_allocator regression: fail");
		end
		$finish;
	end

	// Bound the run well beyond the slowest correct run
	initial begin
		#2000000;
		$display("three_class_block_pool_allocator regression: fail");
		$finish;
	end

endmodule
